// ===== src/ogwc_pkg.sv =====
// Shared types and constants for the occupancy grid window check.
// Grid geometry, cell property codes, beat payloads and control structs.
// No dependencies.
package ogwc_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;

  localparam int COL_W     = $clog2(GRID_WIDTH);
  localparam int ROW_W     = $clog2(GRID_HEIGHT);
  localparam int ADDR_W    = COL_W + ROW_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int MKC_W     = (COL_W > 6) ? COL_W : 6;
  localparam int MKR_W     = (ROW_W > 6) ? ROW_W : 6;

  typedef enum logic [2:0] {
    PROP_AVAILABLE,
    PROP_OBSTACLE,
    PROP_START,
    PROP_TERMINAL,
    PROP_ARRIVED
  } prop_e;

  typedef enum logic [1:0] {
    ACT_WRITE,
    ACT_CHECK,
    ACT_INIT
  } action_e;

  localparam logic [1:0] REG_START_X    = 2'd0;
  localparam logic [1:0] REG_START_Y    = 2'd1;
  localparam logic [1:0] REG_TERMINAL_X = 2'd2;
  localparam logic [1:0] REG_TERMINAL_Y = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        radius;
    logic [2:0]         property_req;
  } in_item_t;

  typedef struct packed {
    logic       legal;
    logic       at_end;
    logic [5:0] current_start_x;
    logic [5:0] current_start_y;
    logic [5:0] current_terminal_x;
    logic [5:0] current_terminal_y;
  } out_item_t;

  typedef struct packed {
    logic [5:0] start_x;
    logic [5:0] start_y;
    logic [5:0] terminal_x;
    logic [5:0] terminal_y;
  } cfg_t;

  typedef struct packed {
    logic             in_map;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] x0;
    logic [COL_W-1:0] x1;
    logic [ROW_W-1:0] y0;
    logic [ROW_W-1:0] y1;
  } win_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        wdata;
  } mem_req_t;

endpackage

// ===== src/ogwc_cell_mem.sv =====
// Cell property store: one port, synchronous write, registered read.
// Depends on ogwc_pkg for the grid address width and request struct.
module ogwc_cell_mem
  import ogwc_pkg::*;
(
  input  logic       clk_i,
  input  mem_req_t   req_i,
  output logic [2:0] rdata_o
);

  logic [2:0] cells_q [MEM_DEPTH];
  logic [2:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      cells_q[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= cells_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ogwc_window.sv =====
// Cell selection and window bounds from a signed Q8.8 position and a Q7.8 radius.
// Floor of p-r and ceil of p+r per axis, clamped to the grid.
// Depends on ogwc_pkg.
module ogwc_window
  import ogwc_pkg::*;
(
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [14:0]        radius_i,
  output win_t               win_o
);

  logic [16:0] lo_x, lo_y;
  logic [17:0] hi_x, hi_y;
  logic        in_x, in_y;

  assign in_x = !pos_x_i[15] && ({1'b0, pos_x_i[15:8]} < 9'(GRID_WIDTH));
  assign in_y = !pos_y_i[15] && ({1'b0, pos_y_i[15:8]} < 9'(GRID_HEIGHT));

  assign lo_x = {pos_x_i[15], pos_x_i} - {2'b00, radius_i};
  assign lo_y = {pos_y_i[15], pos_y_i} - {2'b00, radius_i};
  assign hi_x = 18'(pos_x_i[14:0]) + 18'(radius_i) + 18'd255;
  assign hi_y = 18'(pos_y_i[14:0]) + 18'(radius_i) + 18'd255;

  always_comb begin
    win_o.in_map = in_x && in_y;
    win_o.col    = pos_x_i[8+COL_W-1:8];
    win_o.row    = pos_y_i[8+ROW_W-1:8];
    win_o.x0     = lo_x[16] ? '0 : lo_x[8+COL_W-1:8];
    win_o.y0     = lo_y[16] ? '0 : lo_y[8+ROW_W-1:8];
    win_o.x1     = (hi_x[17:8] > 10'(GRID_WIDTH - 1)) ? COL_W'(GRID_WIDTH - 1)
                                                      : hi_x[8+COL_W-1:8];
    win_o.y1     = (hi_y[17:8] > 10'(GRID_HEIGHT - 1)) ? ROW_W'(GRID_HEIGHT - 1)
                                                       : hi_y[8+ROW_W-1:8];
  end

endmodule

// ===== src/ogwc_ctrl.sv =====
// Sequencer: decodes each item, clears and marks the grid, scans check windows
// through the cell store, tracks markers and holds the result beat.
// Depends on ogwc_pkg, ogwc_window and ogwc_cell_mem.
module ogwc_ctrl
  import ogwc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_CLEAR  = 3'd2;
  localparam logic [2:0] ST_MARK_S = 3'd3;
  localparam logic [2:0] ST_MARK_T = 3'd4;
  localparam logic [2:0] ST_SCAN   = 3'd5;
  localparam logic [2:0] ST_DRAIN  = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [2:0]        state_q, state_d;
  in_item_t          item_q;
  win_t              win, win_q, win_d;
  logic [COL_W-1:0]  cx_q, cx_d;
  logic [ROW_W-1:0]  cy_q, cy_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              rd_pend_q, rd_pend_d;
  logic              boot_q, boot_d;
  logic              legal_q, legal_d;
  logic [MKC_W-1:0]  sc_q, sc_d, gc_q, gc_d;
  logic [MKR_W-1:0]  sr_q, sr_d, gr_q, gr_d;
  logic              goal_arr_q, goal_arr_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q;
  logic              load_out;
  logic              obst;
  logic              wr_ok;
  logic [2:0]        rdata;
  mem_req_t          mem_req;

  ogwc_window u_window (
    .pos_x_i  (item_q.pos_x),
    .pos_y_i  (item_q.pos_y),
    .radius_i (item_q.radius),
    .win_o    (win)
  );

  ogwc_cell_mem u_cell_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign obst       = rd_pend_q && (rdata == PROP_OBSTACLE);
  assign wr_ok      = win.in_map && (item_q.property_req <= PROP_ARRIVED);
  assign load_out   = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d    = state_q;
    win_d      = win_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    clr_d      = clr_q;
    rd_pend_d  = 1'b0;
    boot_d     = boot_q;
    legal_d    = legal_q;
    sc_d       = sc_q;
    sr_d       = sr_q;
    gc_d       = gc_q;
    gr_d       = gr_q;
    goal_arr_d = goal_arr_q;
    mem_req    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        legal_d = 1'b1;
        state_d = ST_FINISH;
        unique case (item_q.action)
          ACT_WRITE: begin
            if (wr_ok) begin
              mem_req.we    = 1'b1;
              mem_req.addr  = {win.row, win.col};
              mem_req.wdata = item_q.property_req;
              if (gc_q == MKC_W'(win.col) && gr_q == MKR_W'(win.row)) begin
                goal_arr_d = (item_q.property_req == PROP_ARRIVED);
              end
              if (item_q.property_req == PROP_START) begin
                sc_d = MKC_W'(win.col);
                sr_d = MKR_W'(win.row);
              end
              if (item_q.property_req == PROP_TERMINAL) begin
                gc_d       = MKC_W'(win.col);
                gr_d       = MKR_W'(win.row);
                goal_arr_d = 1'b0;
              end
            end
          end
          ACT_CHECK: begin
            if (!win.in_map) begin
              legal_d = 1'b0;
            end else begin
              win_d   = win;
              cx_d    = win.x0;
              cy_d    = win.y0;
              state_d = ST_SCAN;
            end
          end
          ACT_INIT: begin
            sc_d    = MKC_W'(cfg_i.start_x);
            sr_d    = MKR_W'(cfg_i.start_y);
            gc_d    = MKC_W'(cfg_i.terminal_x);
            gr_d    = MKR_W'(cfg_i.terminal_y);
            clr_d   = '0;
            state_d = ST_CLEAR;
          end
          default: ;
        endcase
      end
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_q;
        mem_req.wdata = PROP_AVAILABLE;
        clr_d         = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = ST_MARK_S;
        end
      end
      ST_MARK_S: begin
        mem_req.we    = ({1'b0, sc_q} < (MKC_W+1)'(GRID_WIDTH)) &&
                        ({1'b0, sr_q} < (MKR_W+1)'(GRID_HEIGHT));
        mem_req.addr  = {sr_q[ROW_W-1:0], sc_q[COL_W-1:0]};
        mem_req.wdata = PROP_START;
        state_d       = ST_MARK_T;
      end
      ST_MARK_T: begin
        mem_req.we    = ({1'b0, gc_q} < (MKC_W+1)'(GRID_WIDTH)) &&
                        ({1'b0, gr_q} < (MKR_W+1)'(GRID_HEIGHT));
        mem_req.addr  = {gr_q[ROW_W-1:0], gc_q[COL_W-1:0]};
        mem_req.wdata = PROP_TERMINAL;
        goal_arr_d    = 1'b0;
        boot_d        = 1'b0;
        legal_d       = 1'b1;
        state_d       = boot_q ? ST_IDLE : ST_FINISH;
      end
      ST_SCAN: begin
        if (obst) begin
          legal_d = 1'b0;
          state_d = ST_FINISH;
        end else begin
          mem_req.re   = 1'b1;
          mem_req.addr = {cy_q, cx_q};
          rd_pend_d    = 1'b1;
          if (cx_q == win_q.x1) begin
            cx_d = win_q.x0;
            cy_d = cy_q + 1'b1;
            if (cy_q == win_q.y1) begin
              state_d = ST_DRAIN;
            end
          end else begin
            cx_d = cx_q + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        legal_d = !obst;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rd_pend_q   <= 1'b0;
      boot_q      <= 1'b1;
      sc_q        <= '0;
      sr_q        <= '0;
      gc_q        <= '0;
      gr_q        <= '0;
      goal_arr_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rd_pend_q   <= rd_pend_d;
      boot_q      <= boot_d;
      sc_q        <= sc_d;
      sr_q        <= sr_d;
      gc_q        <= gc_d;
      gr_q        <= gr_d;
      goal_arr_q  <= goal_arr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q   <= win_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    legal_q <= legal_d;
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (load_out) begin
      out_q.legal              <= legal_q;
      out_q.at_end             <= goal_arr_q;
      out_q.current_start_x    <= sc_q[5:0];
      out_q.current_start_y    <= sr_q[5:0];
      out_q.current_terminal_x <= gc_q[5:0];
      out_q.current_terminal_y <= gr_q[5:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DECODE))
    else $error("accepted beat not decoded");

  a_scan_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cx_q <= win_q.x1 && cy_q <= win_q.y1))
    else $error("scan position outside window");

  a_drain_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> rd_pend_q)
    else $error("drain without a pending read");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> !(state_q == ST_SCAN || state_q == ST_DRAIN))
    else $error("cell write during window scan");

  a_mark_clears_arrived: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MARK_T) |=> !goal_arr_q)
    else $error("arrived flag survives init");

endmodule

// ===== src/occupancy_grid_window_check.sv =====
// Top level of the occupancy grid window check: configuration registers on an
// APB-style port and the item sequencer. Depends on ogwc_pkg and ogwc_ctrl.
//
// One item is in flight at a time; every beat gives one result beat, and the
// next item is taken once the previous one is finished. A window check reads
// its cells through the single cell-store port one cell per cycle, and stops
// early when an obstacle is found. Initialize clears all 4096 cells one per
// cycle and then marks the start and terminal cells. After reset the same
// clearing pass runs before the first item is taken; configuration writes are
// taken throughout. Registers act at the next initialize.
module occupancy_grid_window_check
  import ogwc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  cfg_t cfg_q;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_START_X:    cfg_q.start_x    <= pwdata[5:0];
        REG_START_Y:    cfg_q.start_y    <= pwdata[5:0];
        REG_TERMINAL_X: cfg_q.terminal_x <= pwdata[5:0];
        REG_TERMINAL_Y: cfg_q.terminal_y <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START_X:    prdata = 32'(cfg_q.start_x);
      REG_START_Y:    prdata = 32'(cfg_q.start_y);
      REG_TERMINAL_X: prdata = 32'(cfg_q.terminal_x);
      REG_TERMINAL_Y: prdata = 32'(cfg_q.terminal_y);
      default:        prdata = '0;
    endcase
  end

  ogwc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/sv/grid_report_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the occupancy grid window check: tracks marker registers
// from the APB port, predicts each result beat, and compares it field by field.
// Depends on ogwc_pkg.
module grid_report_checker
  import ogwc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_data_i,
  output int          mismatch_count_o,
  output int          pending_o
);

  cfg_t       marker_cfg;
  prop_e      cells [GRID_HEIGHT][GRID_WIDTH];
  logic [5:0] start_col, start_row, goal_col, goal_row;
  out_item_t  expected_reports [$];

  function automatic void clear_grid();
    foreach (cells[r, c]) cells[r][c] = PROP_AVAILABLE;
    start_col = marker_cfg.start_x;
    start_row = marker_cfg.start_y;
    goal_col  = marker_cfg.terminal_x;
    goal_row  = marker_cfg.terminal_y;
    cells[start_row][start_col] = PROP_START;
    cells[goal_row][goal_col]   = PROP_TERMINAL;
  endfunction

  function automatic logic window_free(int px, int py, int rad);
    int x0, x1, y0, y1;
    if (px < 0 || px >= GRID_WIDTH * 256 || py < 0 || py >= GRID_HEIGHT * 256) begin
      return 1'b0;
    end
    x0 = (px - rad) >>> 8;
    y0 = (py - rad) >>> 8;
    x1 = (px + rad + 255) >>> 8;
    y1 = (py + rad + 255) >>> 8;
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > GRID_WIDTH - 1) x1 = GRID_WIDTH - 1;
    if (y1 > GRID_HEIGHT - 1) y1 = GRID_HEIGHT - 1;
    for (int r = y0; r <= y1; r++) begin
      for (int c = x0; c <= x1; c++) begin
        if (cells[r][c] == PROP_OBSTACLE) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic out_item_t run_action(in_item_t item);
    out_item_t rep;
    int        col, row;
    rep.legal = 1'b1;
    case (item.action)
      ACT_WRITE: begin
        col = int'($signed(item.pos_x[15:8]));
        row = int'($signed(item.pos_y[15:8]));
        if (item.property_req <= PROP_ARRIVED && col >= 0 && col < GRID_WIDTH &&
            row >= 0 && row < GRID_HEIGHT) begin
          cells[row][col] = prop_e'(item.property_req);
          if (item.property_req == PROP_START) begin
            start_col = col[5:0];
            start_row = row[5:0];
          end
          if (item.property_req == PROP_TERMINAL) begin
            goal_col = col[5:0];
            goal_row = row[5:0];
          end
        end
      end
      ACT_CHECK: rep.legal = window_free(int'($signed(item.pos_x)),
                                        int'($signed(item.pos_y)),
                                        int'(item.radius));
      ACT_INIT:  clear_grid();
      default: ;
    endcase
    rep.at_end             = (cells[goal_row][goal_col] == PROP_ARRIVED);
    rep.current_start_x    = start_col;
    rep.current_start_y    = start_row;
    rep.current_terminal_x = goal_col;
    rep.current_terminal_y = goal_row;
    return rep;
  endfunction

  task automatic check_field(input string name, input logic [5:0] want, input logic [5:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    out_item_t want;
    if (!rst_ni) begin
      marker_cfg = '0;
      clear_grid();
      expected_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_START_X:    marker_cfg.start_x    = pwdata[5:0];
          REG_START_Y:    marker_cfg.start_y    = pwdata[5:0];
          REG_TERMINAL_X: marker_cfg.terminal_x = pwdata[5:0];
          REG_TERMINAL_Y: marker_cfg.terminal_y = pwdata[5:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_reports.push_back(run_action(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          $error("result beat with nothing expected");
          mismatch_count_o++;
        end else begin
          want = expected_reports.pop_front();
          check_field("legal", 6'(want.legal), 6'(out_data_i.legal));
          check_field("at_end", 6'(want.at_end), 6'(out_data_i.at_end));
          check_field("current_start_x", want.current_start_x, out_data_i.current_start_x);
          check_field("current_start_y", want.current_start_y, out_data_i.current_start_y);
          check_field("current_terminal_x", want.current_terminal_x,
                      out_data_i.current_terminal_x);
          check_field("current_terminal_y", want.current_terminal_y,
                      out_data_i.current_terminal_y);
        end
      end
    end
    pending_o = expected_reports.size();
  end

endmodule

// ===== tb/sv/occupancy_grid_window_check_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the occupancy grid window check: clock, reset, marker
// register writes, directed and random item beats, and the verdict.
// Depends on ogwc_pkg, occupancy_grid_window_check and grid_report_checker.
module occupancy_grid_window_check_tb;
  import ogwc_pkg::*;

  localparam int         STALL_LIMIT      = 40000;
  localparam int         ITEMS_PER_PHASE  = 288;
  localparam int         CELL_Q           = 256;
  localparam int         FOCUS_CELLS      = 16;
  localparam logic [1:0] ACT_SPARE        = 2'd3;
  localparam logic [2:0] PROP_RESERVED_LO = 3'd5;
  localparam logic [2:0] PROP_RESERVED_HI = 3'd7;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches;
  int pending;

  occupancy_grid_window_check dut (.*);

  grid_report_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_data_i      (out_data_o),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic send_item(input logic [1:0] act, input int x, input int y, input int rad,
                           input logic [2:0] prop);
    in_item_t item;
    item.action       = act;
    item.pos_x        = x[15:0];
    item.pos_y        = y[15:0];
    item.radius       = rad[14:0];
    item.property_req = prop;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic set_markers(input logic [5:0] sx, input logic [5:0] sy,
                             input logic [5:0] tx, input logic [5:0] ty);
    logic [5:0] vals [4];
    logic [1:0] regs [4];
    vals = '{sx, sy, tx, ty};
    regs = '{REG_START_X, REG_START_Y, REG_TERMINAL_X, REG_TERMINAL_Y};
    for (int i = 0; i < 4; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {regs[i], 2'b00};
      pwdata  <= {26'd0, vals[i]};
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic int pick_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, FOCUS_CELLS * CELL_Q - 1);
    if (r < 90) return $urandom_range(0, GRID_WIDTH * CELL_Q - 1);
    return $urandom_range(0, 65535);
  endfunction

  function automatic logic [2:0] pick_prop();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return PROP_OBSTACLE;
    if (r < 80) return PROP_AVAILABLE;
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic int pick_radius();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 3 * CELL_Q - 1);
    if (r < 98) return $urandom_range(0, 8 * CELL_Q - 1);
    return $urandom_range(0, 32767);
  endfunction

  task automatic run_directed();
    send_item(ACT_CHECK, 0, 0, 0, PROP_AVAILABLE);
    send_item(ACT_WRITE, 5 * CELL_Q + 128, 5 * CELL_Q + 255, 0, PROP_OBSTACLE);
    send_item(ACT_CHECK, 5 * CELL_Q, 5 * CELL_Q, 0, PROP_AVAILABLE);
    send_item(ACT_CHECK, 3 * CELL_Q + 128, 3 * CELL_Q + 128, 64, PROP_AVAILABLE);
    send_item(ACT_CHECK, 3 * CELL_Q, 3 * CELL_Q, 2 * CELL_Q, PROP_AVAILABLE);
    send_item(ACT_CHECK, -1, 0, 0, PROP_AVAILABLE);
    send_item(ACT_CHECK, 0, GRID_HEIGHT * CELL_Q, 0, PROP_AVAILABLE);
    send_item(ACT_CHECK, -32768, 32767, 32767, PROP_RESERVED_HI);
    send_item(ACT_CHECK, 40 * CELL_Q, 40 * CELL_Q, 32767, PROP_AVAILABLE);
    send_item(ACT_WRITE, 5 * CELL_Q, 5 * CELL_Q, 32767, PROP_AVAILABLE);
    send_item(ACT_CHECK, 0, 0, 32767, PROP_AVAILABLE);
    send_item(ACT_WRITE, GRID_WIDTH * CELL_Q - 1, GRID_HEIGHT * CELL_Q - 1, 0, PROP_START);
    send_item(ACT_WRITE, 10 * CELL_Q, 20 * CELL_Q, 0, PROP_TERMINAL);
    send_item(ACT_WRITE, 10 * CELL_Q, 20 * CELL_Q, 0, PROP_ARRIVED);
    send_item(ACT_WRITE, 10 * CELL_Q, 20 * CELL_Q, 0, PROP_RESERVED_LO);
    send_item(ACT_WRITE, 10 * CELL_Q, 20 * CELL_Q, 0, PROP_RESERVED_HI);
    send_item(ACT_WRITE, -1, 0, 0, PROP_OBSTACLE);
    send_item(ACT_WRITE, GRID_WIDTH * CELL_Q, 0, 0, PROP_OBSTACLE);
    send_item(ACT_WRITE, 0, -32768, 0, PROP_START);
    send_item(ACT_WRITE, 63 * CELL_Q, 0, 0, PROP_OBSTACLE);
    send_item(ACT_CHECK, GRID_WIDTH * CELL_Q - 1, 0, 300, PROP_AVAILABLE);
    send_item(ACT_SPARE, -32768, -32768, 32767, PROP_RESERVED_HI);
    send_item(ACT_INIT, 32767, 32767, 32767, PROP_OBSTACLE);
    send_item(ACT_CHECK, GRID_WIDTH * CELL_Q - 1, 0, 300, PROP_AVAILABLE);
  endtask

  task automatic run_random(input int count);
    int done, roll, x, y;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 38) begin
        send_item(ACT_WRITE, pick_pos(), pick_pos(), $urandom_range(0, 32767), pick_prop());
        done++;
      end else if (roll < 76) begin
        send_item(ACT_CHECK, pick_pos(), pick_pos(), pick_radius(), 3'($urandom_range(0, 7)));
        done++;
      end else if (roll < 84) begin
        // move the terminal, then mark it arrived
        x = $urandom_range(0, FOCUS_CELLS * CELL_Q - 1);
        y = $urandom_range(0, FOCUS_CELLS * CELL_Q - 1);
        send_item(ACT_WRITE, x, y, 0, PROP_TERMINAL);
        send_item(ACT_WRITE, x ^ $urandom_range(0, 255), y, 0, PROP_ARRIVED);
        done += 2;
      end else if (roll < 89) begin
        send_item(ACT_WRITE, $urandom_range(0, FOCUS_CELLS * CELL_Q - 1),
                  $urandom_range(0, FOCUS_CELLS * CELL_Q - 1), 0, PROP_START);
        done++;
      end else if (roll < 95) begin
        send_item(2'($urandom), $urandom, $urandom, $urandom, 3'($urandom));
        done++;
      end else if (roll < 97) begin
        send_item(ACT_INIT, 0, 0, 0, PROP_AVAILABLE);
        done++;
      end else begin
        send_item(ACT_SPARE, $urandom, $urandom, $urandom, 3'($urandom));
        done++;
      end
    end
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("occupancy_grid_window_check: mismatch");
    $finish;
  end

  initial begin : stimulus
    logic [5:0] cell_x, cell_y;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      @(posedge clk_i);
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          set_markers(6'd63, 6'd63, 6'd0, 6'd0);
        end
        1: begin
          send_idle_pct  = 87;
          recv_stall_pct = 0;
          set_markers(6'd0, 6'd0, 6'd63, 6'd63);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 87;
          set_markers(6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom));
        end
        default: begin
          send_idle_pct  = 13;
          recv_stall_pct = 13;
          cell_x = 6'($urandom);
          cell_y = 6'($urandom);
          set_markers(cell_x, cell_y, cell_x, cell_y);
        end
      endcase
      if (phase == 0) run_directed();
      else send_item(ACT_INIT, 0, 0, 0, PROP_AVAILABLE);
      run_random(ITEMS_PER_PHASE);
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      wait (pending == 0);
    end
    repeat (32) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("occupancy_grid_window_check: match");
    end else begin
      $display("occupancy_grid_window_check: mismatch");
    end
    $finish;
  end

endmodule
